// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/fatcc_pkg.sv -----
package fatcc_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int ENTRY_BITS_DEF  = 28;
  localparam int FIELD_BITS      = 28;
  localparam logic [12:0] TABLE_SIZE_RST = 13'd4096;

  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_READ   = 3'd1,
    MODE_CREATE = 3'd2,
    MODE_APPEND = 3'd3,
    MODE_DELETE = 3'd4,
    MODE_FREE   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RESERVED  = 3'd1,
    ST_FREE_LINK = 3'd2,
    ST_BAD_LINK  = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_TGT   = 3'd5,
    ST_RANGE     = 3'd6,
    ST_LOOP      = 3'd7
  } status_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [FIELD_BITS-1:0] cluster_index;
    logic [FIELD_BITS-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] result_cluster;
    logic [2:0]            status;
  } out_item_t;

endpackage

// ----- rtl/core/fat_cluster_chain_manager_unit.sv -----
// FAT32 cluster chain manager.
// Input channel in_valid/in_stall carries one request (mode, cluster_index,
// entry_value); the result channel out_valid/out_stall returns one
// (result_cluster, status) per request. A transfer happens on a clock edge
// with valid high and stall low.
// Requests run one at a time on a sequencer around a table RAM with one
// write port and one registered read port: a table read presents the
// address, then uses the registered data. Create scans from entry 2 for a
// free slot. Append and delete walk the chain, append then scans; free
// chain clears each link as it walks.
// in_stall is high while a request is in progress or its result waits.
// The result is held in an output register until taken; the next request
// is accepted from the cycle after the result transfers.
// cfg_we writes table_size (entries in use, capped at TABLE_DEPTH); the
// user must write it only while idle, as the block does not enforce this.
// Reset (rst_n low, synchronous) sets table_size to 4096 and empties the
// pipeline; table contents are undefined until loaded.
`include "assert_macros.svh"

module fat_cluster_chain_manager_unit #(
  parameter int TABLE_DEPTH = fatcc_pkg::TABLE_DEPTH_DEF,
  parameter int ENTRY_BITS  = fatcc_pkg::ENTRY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fatcc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fatcc_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FB = fatcc_pkg::FIELD_BITS;
  localparam logic [ENTRY_BITS-1:0] ENT_MASK = {ENTRY_BITS{1'b1}};
  localparam logic [ENTRY_BITS-1:0] BAD_CODE = ENT_MASK - ENTRY_BITS'(8);
  localparam logic [ENTRY_BITS-1:0] END_CODE = ENT_MASK - ENTRY_BITS'(7);
  localparam logic [ENTRY_BITS-1:0] FREE_CODE = '0;
  localparam int NW = AW + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HEAD  = 9'b000000010,
    S_WRD   = 9'b000000100,
    S_WCHK  = 9'b000001000,
    S_SRD   = 9'b000010000,
    S_SCHK  = 9'b000100000,
    S_FIX   = 9'b001000000,
    S_FIX2  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [12:0] table_size_r;
  logic [2:0] mode_r, mode_nxt;
  logic [FB-1:0] idx_r, idx_nxt;
  logic [ENTRY_BITS-1:0] val_r, val_nxt;
  logic [AW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, last_r, last_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [FB-1:0] res_r, res_nxt;
  logic [2:0] st_r, st_nxt;
  logic out_valid_r, out_valid_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ENTRY_BITS-1:0] wdata, rdata;

  logic [NW-1:0] n;
  logic in_acc, out_acc;
  logic [2:0] link_st;

  assign n = (32'(table_size_r) < TABLE_DEPTH) ? NW'(table_size_r) : NW'(TABLE_DEPTH);
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data.result_cluster = res_r;
  assign out_data.status = st_r;

  fatcc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // classify a fetched link
  always_comb begin
    priority if (rdata == FREE_CODE) link_st = fatcc_pkg::ST_FREE_LINK;
    else if (rdata == BAD_CODE) link_st = fatcc_pkg::ST_BAD_LINK;
    else if (rdata >= END_CODE) link_st = fatcc_pkg::ST_OK;
    else if (rdata < ENTRY_BITS'(2) || 32'(rdata) >= 32'(n)) link_st = fatcc_pkg::ST_RANGE;
    else link_st = fatcc_pkg::ST_OK;
  end

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r; idx_nxt = idx_r; val_nxt = val_r;
    cur_nxt = cur_r; prev_nxt = prev_r; last_nxt = last_r; cnt_nxt = cnt_r;
    res_nxt = res_r; st_nxt = st_r; out_valid_nxt = out_valid_r;
    we = 1'b0; waddr = cur_r; wdata = val_r; raddr = cur_r;
    if (out_acc) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_data.mode;
          idx_nxt = in_data.cluster_index;
          val_nxt = in_data.entry_value[ENTRY_BITS-1:0];
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        res_nxt = '0;
        st_nxt = fatcc_pkg::ST_OK;
        cur_nxt = idx_r[AW-1:0];
        prev_nxt = idx_r[AW-1:0];
        cnt_nxt = '0;
        state_nxt = S_DONE;
        unique case (mode_r)
          fatcc_pkg::MODE_LOAD, fatcc_pkg::MODE_READ: begin
            if (32'(idx_r) >= 32'(n)) st_nxt = fatcc_pkg::ST_RANGE;
            else if (mode_r == fatcc_pkg::MODE_LOAD) begin
              we = 1'b1; waddr = idx_r[AW-1:0]; wdata = val_r;
            end else begin
              raddr = idx_r[AW-1:0]; state_nxt = S_WRD;
            end
          end
          fatcc_pkg::MODE_CREATE: begin
            cur_nxt = AW'(2);
            state_nxt = S_SRD;
          end
          fatcc_pkg::MODE_APPEND, fatcc_pkg::MODE_DELETE, fatcc_pkg::MODE_FREE: begin
            if (idx_r < FB'(2)) st_nxt = fatcc_pkg::ST_RESERVED;
            else if (32'(idx_r) >= 32'(n)) st_nxt = fatcc_pkg::ST_RANGE;
            else state_nxt = S_WRD;
          end
          default: st_nxt = fatcc_pkg::ST_RANGE;
        endcase
      end
      S_WRD: begin
        // address cur_r is presented; data arrives next cycle
        raddr = cur_r;
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (mode_r == fatcc_pkg::MODE_READ) begin
          res_nxt = FB'(rdata);
          state_nxt = S_DONE;
        end else if (link_st != fatcc_pkg::ST_OK) begin
          st_nxt = link_st;
          state_nxt = S_DONE;
        end else begin
          if (mode_r == fatcc_pkg::MODE_FREE) begin
            we = 1'b1; waddr = cur_r; wdata = FREE_CODE;
          end
          if (rdata >= END_CODE) begin
            last_nxt = cur_r;
            unique case (mode_r)
              fatcc_pkg::MODE_APPEND: begin
                cur_nxt = AW'(2);
                state_nxt = S_SRD;
              end
              fatcc_pkg::MODE_DELETE: state_nxt = S_FIX;
              default: state_nxt = S_DONE;
            endcase
          end else if (cnt_r + NW'(1) >= n) begin
            st_nxt = fatcc_pkg::ST_LOOP;
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r + NW'(1);
            prev_nxt = cur_r;
            cur_nxt = rdata[AW-1:0];
            state_nxt = S_WRD;
          end
        end
      end
      S_SRD: begin
        if (32'(cur_r) >= 32'(n) || n < NW'(3)) begin
          st_nxt = fatcc_pkg::ST_FULL;
          state_nxt = S_DONE;
        end else begin
          raddr = cur_r;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rdata == FREE_CODE) begin
          res_nxt = FB'(cur_r);
          we = 1'b1; waddr = cur_r; wdata = END_CODE;
          state_nxt = (mode_r == fatcc_pkg::MODE_APPEND) ? S_FIX : S_DONE;
        end else if (32'(cur_r) + 1 >= 32'(n)) begin
          st_nxt = fatcc_pkg::ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cur_nxt = cur_r + AW'(1);
          state_nxt = S_SRD;
        end
      end
      S_FIX: begin
        we = 1'b1;
        if (mode_r == fatcc_pkg::MODE_APPEND) begin
          waddr = last_r; wdata = ENTRY_BITS'(cur_r);
          state_nxt = S_DONE;
        end else begin
          waddr = prev_r; wdata = END_CODE;
          state_nxt = S_FIX2;
        end
      end
      S_FIX2: begin
        // free the last cluster; a one-cluster chain frees the head itself
        we = 1'b1; waddr = last_r; wdata = FREE_CODE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st_r != fatcc_pkg::ST_OK) res_nxt = '0;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      table_size_r <= fatcc_pkg::TABLE_SIZE_RST;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) table_size_r <= cfg_data;
    end
    mode_r <= mode_nxt; idx_r <= idx_nxt; val_r <= val_nxt;
    cur_r <= cur_nxt; prev_r <= prev_nxt; last_r <= last_nxt; cnt_r <= cnt_nxt;
    res_r <= res_nxt; st_r <= st_nxt;
  end

  `ASSERT_CLK(a_busy_stall, clk, rst_n, (state_r != S_IDLE) |-> in_stall, "busy but not stalling")
  `ASSERT_CLK(a_done_valid, clk, rst_n, (state_r == S_DONE) |=> out_valid, "result not raised")
  `ASSERT_CLK(a_err_zero, clk, rst_n, (out_valid && out_data.status != fatcc_pkg::ST_OK) |-> (out_data.result_cluster == '0), "error with nonzero result")
  `ASSERT_ALWAYS(a_state_hot, clk, $onehot(state_r) || !rst_n || $past(!rst_n), "state not one-hot")

endmodule

// ----- rtl/core/fatcc_ram.sv -----
module fatcc_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
